### rtl/core/assert_macros.svh
// Assertion helpers shared by the ray caster RTL.
// Both macros clock on the rising edge of clock and are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define RDC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication: whenever ante holds, cons holds in the same cycle.
`define RDC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/core/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster package
// Widths, constants, types and state codes shared by the ray caster modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

   // Geometry and number format.
   localparam int FRAC_BITS      = 16;
   localparam int MAP_ROWS       = 32;
   localparam int MAP_COLS       = 32;
   localparam int SCREEN_COLUMNS = 640;
   localparam int SCREEN_ROWS    = 480;

   // Field widths.
   localparam int POS_W  = 21;
   localparam int VEC_W  = 19;
   localparam int COL_W  = 10;
   localparam int IDX_W  = 5;
   localparam int CELL_W = 3;
   localparam int ROW_W  = 9;
   localparam int DIST_W = 24;

   // Map store.
   localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);

   // Internal datapath widths.
   localparam int CRD_W    = 10;
   localparam int RAY_W    = VEC_W + 1;
   localparam int CAM_W    = FRAC_BITS + 2;
   localparam int SIDE_W   = 32;
   localparam int NUM_W    = 2 * FRAC_BITS + 1;
   localparam int DEN_W    = DIST_W;
   localparam int F1_W     = FRAC_BITS + 1;
   localparam int STEP_MAX = MAP_ROWS + MAP_COLS;
   localparam int STEP_CW  = $clog2(STEP_MAX + 1);

   localparam int ONE_UNIT  = 1 << FRAC_BITS;
   localparam int DELTA_MAX = (1 << (FRAC_BITS + 8)) - 1;
   localparam int DIST_MAX  = (1 << DIST_W) - 1;
   localparam int HALF_ROWS = SCREEN_ROWS / 2;

   // Camera coordinate offset floor(column * 2^(F+1) / SCREEN_COLUMNS), formed by
   // multiplying with a rounded-up reciprocal and shifting right by CAM_SH.
   localparam int RECIP_W = 22;
   localparam int CAM_SH  = 14;
   localparam logic [RECIP_W-1:0] CAM_RECIP =
      RECIP_W'(((longint'(1) << (FRAC_BITS + 1 + CAM_SH)) + SCREEN_COLUMNS - 1) /
               SCREEN_COLUMNS);

   // Command queue.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_PLAYER_X  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_PLAYER_Y  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DIR_X     = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DIR_Y     = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_PLANE_X   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_PLANE_Y   = 3'd5;

   // Configuration reset values.
   localparam logic [POS_W-1:0] PLAYER_X_RST = 21'd1441792;
   localparam logic [POS_W-1:0] PLAYER_Y_RST = 21'd786432;
   localparam logic [VEC_W-1:0] DIR_X_RST    = 19'h70000;
   localparam logic [VEC_W-1:0] DIR_Y_RST    = 19'd0;
   localparam logic [VEC_W-1:0] PLANE_X_RST  = 19'd0;
   localparam logic [VEC_W-1:0] PLANE_Y_RST  = 19'd43254;

   // Input kinds.
   localparam logic KIND_MAP_WRITE = 1'b0;
   localparam logic KIND_CAST      = 1'b1;

   // One queued command.
   typedef struct packed {
      logic              kind;
      logic [COL_W-1:0]  column;
      logic [IDX_W-1:0]  cell_row;
      logic [IDX_W-1:0]  cell_col;
      logic [CELL_W-1:0] cell_value;
   } item_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end status seen by the front end.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // One result.
   typedef struct packed {
      logic [DIST_W-1:0] wall_distance;
      logic [CELL_W-1:0] wall_type;
      logic              wall_side;
      logic [ROW_W-1:0]  draw_end;
      logic [ROW_W-1:0]  draw_start;
      logic [COL_W-1:0]  column_out;
   } result_type;

   // Back end sequencer.
   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAM,
      ST_MULX,
      ST_MULY,
      ST_DLX,
      ST_DLX_WAIT,
      ST_DLY,
      ST_DLY_WAIT,
      ST_SIDEX,
      ST_SIDEY,
      ST_STEP,
      ST_CHECK,
      ST_FIN,
      ST_SPAN,
      ST_SPAN_WAIT,
      ST_OUT
   } state_type;

endpackage

### rtl/core/rdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/rdc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_div
   import rdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, q_ff[NUM_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         q_in   = {q_ff[NUM_W-2:0], ge};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

### rtl/core/rdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster command queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module rdc_queue
   import rdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   item_type            slot_ff [QUEUE_DEPTH];
   logic                do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = slot_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/core/rdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster front end
// Accepts input beats, drops those that do nothing and queues the rest.
// ----------------------------------------------------------------------------
module rdc_front
   import rdc_pkg::*;
(
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   input  logic             req_tuser,
   input  queue_status_type q_status,
   input  back_status_type  back_status,
   output logic             push,
   output item_type         push_item
);

   logic useful;

   // Unpack the beat.
   always_comb begin
      push_item.kind       = req_tuser;
      push_item.column     = req_tdata[9:0];
      push_item.cell_row   = req_tdata[14:10];
      push_item.cell_col   = req_tdata[19:15];
      push_item.cell_value = req_tdata[22:20];
   end

   // A cast off the screen and a write off the map have no effect.
   always_comb begin
      if (push_item.kind == KIND_CAST) begin
         useful = (int'(push_item.column) < SCREEN_COLUMNS);
      end else begin
         useful = (int'(push_item.cell_row) < MAP_ROWS) &&
                  (int'(push_item.cell_col) < MAP_COLS);
      end
   end

   assign req_tready = !q_status.full && !back_status.clearing;
   assign push       = req_tvalid && req_tready && useful;

endmodule

### rtl/core/rdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster back end
// Holds the map and configuration, walks each ray and drives the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_back
   import rdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [POS_W-1:0]    csr_wdata,
   input  item_type            head_item,
   input  queue_status_type    q_status,
   output logic                pop,
   output back_status_type     status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output result_type          rsp
);

   state_type state_ff, state_in;

   // Configuration.
   logic [POS_W-1:0]        player_x_ff, player_y_ff;
   logic signed [VEC_W-1:0] view_dir_x_ff, view_dir_y_ff;
   logic signed [VEC_W-1:0] camera_plane_x_ff, camera_plane_y_ff;

   // Ray state.
   logic [COL_W-1:0]         column_ff, column_in;
   logic signed [CAM_W-1:0]  cam_ff, cam_in;
   logic signed [RAY_W-1:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic [DEN_W-1:0]         dx_ff, dx_in, dy_ff, dy_in;
   logic [SIDE_W-1:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CRD_W-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [STEP_CW-1:0]       n_ff, n_in;
   logic                     side_ff, side_in;
   logic [CELL_W-1:0]        type_ff, type_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [ROW_W-1:0]         half_ff, half_in;
   logic [MAP_AW-1:0]        clr_ff, clr_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   // Shared units and control strobes.
   logic                          div_start, div_done;
   logic [NUM_W-1:0]              div_num, div_quo;
   logic [DEN_W-1:0]              div_den, delta_sat;
   logic                          ram_we;
   logic [MAP_AW-1:0]             ram_waddr, ram_raddr;
   logic [CELL_W-1:0]             ram_wdata, ram_rdata;
   logic                          out_load, out_free;
   logic [COL_W+RECIP_W-1:0]      cam_prod;
   logic signed [VEC_W-1:0]       mul_a;
   logic signed [VEC_W+CAM_W-1:0] mul_p;
   logic signed [RAY_W-1:0]       ray_sel;
   logic [DEN_W-1:0]              ray_abs;
   logic                          ray_zero;
   logic [FRAC_BITS-1:0]          side_frac;
   logic [F1_W-1:0]               side_f;
   logic [F1_W+DEN_W-1:0]         side_p;
   logic signed [CRD_W-1:0]       start_cell;
   logic                          x_first, walk_out;
   logic signed [CRD_W-1:0]       mx_nx, my_nx;
   logic [SIDE_W-1:0]             sx_nx, sy_nx, dist_raw;
   logic [ROW_W-1:0]              span_start, span_end;
   logic [ROW_W:0]                end_sum;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign out_free        = !rsp_valid_ff || rsp_tready;

   // Camera coordinate offset: column times the reciprocal of the screen width.
   assign cam_prod = column_ff * CAM_RECIP;

   // Ray component multiply: plane component times camera coordinate.
   assign mul_a = (state_ff == ST_MULX) ? camera_plane_x_ff : camera_plane_y_ff;
   assign mul_p = mul_a * cam_ff;

   // Magnitude of the ray component whose delta is being formed.
   assign ray_sel  = (state_ff == ST_DLY) ? ry_ff : rx_ff;
   assign ray_zero = (ray_sel == '0);
   assign ray_abs  = ray_sel[RAY_W-1] ? DEN_W'($unsigned(-ray_sel))
                                      : DEN_W'($unsigned(ray_sel));
   assign delta_sat = (div_quo > NUM_W'(DELTA_MAX)) ? DEN_W'(DELTA_MAX)
                                                    : div_quo[DEN_W-1:0];

   // Distance to the first boundary: fraction to the next edge times delta.
   always_comb begin
      if (state_ff == ST_SIDEX) begin
         side_frac  = player_x_ff[FRAC_BITS-1:0];
         start_cell = CRD_W'(player_x_ff >> FRAC_BITS);
         side_f     = rx_ff[RAY_W-1] ? {1'b0, side_frac}
                                     : F1_W'(ONE_UNIT) - {1'b0, side_frac};
         side_p     = side_f * dx_ff;
      end else begin
         side_frac  = player_y_ff[FRAC_BITS-1:0];
         start_cell = CRD_W'(player_y_ff >> FRAC_BITS);
         side_f     = ry_ff[RAY_W-1] ? {1'b0, side_frac}
                                     : F1_W'(ONE_UNIT) - {1'b0, side_frac};
         side_p     = side_f * dy_ff;
      end
   end

   // One DDA step: advance along the nearer boundary, ties go to y.
   always_comb begin
      x_first = (sx_ff < sy_ff);
      mx_nx   = mx_ff;
      my_nx   = my_ff;
      sx_nx   = sx_ff;
      sy_nx   = sy_ff;
      if (x_first) begin
         sx_nx = sx_ff + SIDE_W'(dx_ff);
         mx_nx = rx_ff[RAY_W-1] ? mx_ff - CRD_W'(1) : mx_ff + CRD_W'(1);
      end else begin
         sy_nx = sy_ff + SIDE_W'(dy_ff);
         my_nx = ry_ff[RAY_W-1] ? my_ff - CRD_W'(1) : my_ff + CRD_W'(1);
      end
      walk_out = mx_nx[CRD_W-1] || (mx_nx >= MAP_ROWS) ||
                 my_nx[CRD_W-1] || (my_nx >= MAP_COLS);
      dist_raw = side_ff ? sy_ff - SIDE_W'(dy_ff) : sx_ff - SIDE_W'(dx_ff);
   end

   // Vertical span from the halved wall height.
   always_comb begin
      span_start = (int'(half_ff) > HALF_ROWS) ? '0 : ROW_W'(HALF_ROWS) - half_ff;
      end_sum    = (ROW_W + 1)'(HALF_ROWS) + (ROW_W + 1)'(half_ff);
      span_end   = (int'(end_sum) > SCREEN_ROWS - 1) ? ROW_W'(SCREEN_ROWS - 1)
                                                     : end_sum[ROW_W-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty && head_item.kind == KIND_CAST) begin
               state_in = ST_CAM;
            end
         end
         ST_CAM:       state_in = ST_MULX;
         ST_MULX:      state_in = ST_MULY;
         ST_MULY:      state_in = ST_DLX;
         ST_DLX:       state_in = ray_zero ? ST_DLY : ST_DLX_WAIT;
         ST_DLX_WAIT:  state_in = div_done ? ST_DLY : ST_DLX_WAIT;
         ST_DLY:       state_in = ray_zero ? ST_SIDEX : ST_DLY_WAIT;
         ST_DLY_WAIT:  state_in = div_done ? ST_SIDEX : ST_DLY_WAIT;
         ST_SIDEX:     state_in = ST_SIDEY;
         ST_SIDEY: begin
            if ((mx_ff >= MAP_ROWS) || (start_cell >= MAP_COLS)) begin
               state_in = ST_SPAN;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP:      state_in = walk_out ? ST_FIN : ST_CHECK;
         ST_CHECK: begin
            if (ram_rdata != '0 || n_ff == STEP_CW'(STEP_MAX)) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_FIN:       state_in = ST_SPAN;
         ST_SPAN:      state_in = ST_SPAN_WAIT;
         ST_SPAN_WAIT: state_in = div_done ? ST_OUT : ST_SPAN_WAIT;
         ST_OUT:       state_in = out_free ? ST_IDLE : ST_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control strobes and shared unit operands.
   always_comb begin
      pop       = 1'b0;
      div_start = 1'b0;
      div_num   = NUM_W'(1) << (2 * FRAC_BITS);
      div_den   = ray_abs;
      ram_we    = 1'b0;
      ram_waddr = MAP_AW'(int'(head_item.cell_row) * MAP_COLS + int'(head_item.cell_col));
      ram_wdata = head_item.cell_value;
      ram_raddr = MAP_AW'(int'(mx_nx) * MAP_COLS + int'(my_nx));
      out_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            pop    = !q_status.empty;
            ram_we = !q_status.empty && (head_item.kind == KIND_MAP_WRITE);
         end
         ST_DLX, ST_DLY: begin
            div_start = !ray_zero;
         end
         ST_SPAN: begin
            div_start = 1'b1;
            div_num   = NUM_W'(SCREEN_ROWS) << FRAC_BITS;
            div_den   = dist_ff;
         end
         ST_OUT: begin
            out_load = out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Ray datapath.
   always_comb begin
      column_in = column_ff;
      cam_in    = cam_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      n_in      = n_ff;
      side_in   = side_ff;
      type_in   = type_ff;
      dist_in   = dist_ff;
      half_in   = half_ff;
      clr_in    = clr_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + MAP_AW'(1);
         ST_IDLE:  column_in = head_item.column;
         ST_CAM: begin
            cam_in = $signed(CAM_W'(cam_prod >> CAM_SH) - CAM_W'(ONE_UNIT));
         end
         ST_MULX: rx_in = RAY_W'(view_dir_x_ff) + RAY_W'(mul_p >>> FRAC_BITS);
         ST_MULY: ry_in = RAY_W'(view_dir_y_ff) + RAY_W'(mul_p >>> FRAC_BITS);
         ST_DLX:      dx_in = DEN_W'(DELTA_MAX);
         ST_DLX_WAIT: dx_in = delta_sat;
         ST_DLY:      dy_in = DEN_W'(DELTA_MAX);
         ST_DLY_WAIT: dy_in = delta_sat;
         ST_SIDEX: begin
            sx_in = SIDE_W'(side_p >> FRAC_BITS);
            mx_in = start_cell;
         end
         ST_SIDEY: begin
            sy_in   = SIDE_W'(side_p >> FRAC_BITS);
            my_in   = start_cell;
            n_in    = '0;
            side_in = 1'b0;
            type_in = '0;
            dist_in = DIST_W'(ONE_UNIT);
         end
         ST_STEP: begin
            sx_in   = sx_nx;
            sy_in   = sy_nx;
            mx_in   = mx_nx;
            my_in   = my_nx;
            side_in = !x_first;
            n_in    = n_ff + STEP_CW'(1);
            type_in = '0;
         end
         ST_CHECK: type_in = ram_rdata;
         ST_FIN: begin
            if (dist_raw < SIDE_W'(ONE_UNIT)) begin
               dist_in = DIST_W'(ONE_UNIT);
            end else if (dist_raw > SIDE_W'(DIST_MAX)) begin
               dist_in = DIST_W'(DIST_MAX);
            end else begin
               dist_in = dist_raw[DIST_W-1:0];
            end
         end
         ST_SPAN_WAIT: half_in = ROW_W'(div_quo >> 1);
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   // Result register: refills as soon as the slot is free.
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.column_out    = column_ff;
         rsp_in.draw_start    = span_start;
         rsp_in.draw_end      = span_end;
         rsp_in.wall_side     = side_ff;
         rsp_in.wall_type     = type_ff;
         rsp_in.wall_distance = dist_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff       <= PLAYER_X_RST;
         player_y_ff       <= PLAYER_Y_RST;
         view_dir_x_ff     <= DIR_X_RST;
         view_dir_y_ff     <= DIR_Y_RST;
         camera_plane_x_ff <= PLANE_X_RST;
         camera_plane_y_ff <= PLANE_Y_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLAYER_X: player_x_ff       <= csr_wdata;
            CSR_PLAYER_Y: player_y_ff       <= csr_wdata;
            CSR_DIR_X:    view_dir_x_ff     <= csr_wdata[VEC_W-1:0];
            CSR_DIR_Y:    view_dir_y_ff     <= csr_wdata[VEC_W-1:0];
            CSR_PLANE_X:  camera_plane_x_ff <= csr_wdata[VEC_W-1:0];
            CSR_PLANE_Y:  camera_plane_y_ff <= csr_wdata[VEC_W-1:0];
            default:      player_x_ff       <= player_x_ff;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      column_ff <= column_in;
      cam_ff    <= cam_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      n_ff      <= n_in;
      side_ff   <= side_in;
      type_ff   <= type_in;
      dist_ff   <= dist_in;
      half_ff   <= half_in;
      rsp_ff    <= rsp_in;
   end

   rdc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   rdc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   // The divider only finishes while the sequencer waits for it.
   `RDC_ASSERT_IMP(a_div_done_waited, div_done,
      state_ff == ST_DLX_WAIT || state_ff == ST_DLY_WAIT || state_ff == ST_SPAN_WAIT,
      "divider result arrived outside a wait state")
   // Every result carries a distance of at least one unit.
   `RDC_ASSERT_IMP(a_dist_floor, out_load, dist_ff >= DIST_W'(ONE_UNIT),
      "result distance below one unit")
   // A map read is only checked after at least one step.
   `RDC_ASSERT_IMP(a_check_after_step, state_ff == ST_CHECK, n_ff != '0,
      "map check without a preceding step")

endmodule

### rtl/core/grid_ray_caster_dda_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster core
// Casts one ray per screen column through a 32 x 32 map of wall types.
// ----------------------------------------------------------------------------
// After reset the map store is cleared to empty floor, during which req_tready
// stays low; configuration writes are taken throughout. A map write beat is
// consumed from the idle state and gives no result. A cast makes one to three
// divisions on the shared bit-serial divider (a zero ray component skips its
// division), passes setup states for the camera coordinate, the ray components
// and the first boundaries, then takes a step state and a check state per grid
// cell crossed, set by the registered read of the map memory in the walk loop,
// up to 64 cells. Incoming beats queue in a four-entry buffer ahead of the walker,
// and a finished result waits in the output register while the next cast runs.
// ----------------------------------------------------------------------------
module grid_ray_caster_dda_core
   import rdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Configuration write port.
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [POS_W-1:0]  csr_wdata,
   // Command stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,  // column, cell_row, cell_col, cell_value
   input  logic              req_tuser,  // kind
   // Result stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // column_out, draw_start, draw_end, wall_side, wall_type, wall_distance
   output logic [55:0]       rsp_tdata
);

   item_type         push_item, head_item;
   logic             push, pop;
   queue_status_type q_status;
   back_status_type  back_status;
   result_type       rsp;

   rdc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_status    (q_status),
      .back_status (back_status),
      .push        (push),
      .push_item   (push_item)
   );

   rdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   rdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_item  (head_item),
      .q_status   (q_status),
      .pop        (pop),
      .status     (back_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result beat, first field in the lowest bits.
   assign rsp_tdata = {rsp.wall_distance, rsp.wall_type, rsp.wall_side,
                       rsp.draw_end, rsp.draw_start, rsp.column_out};

endmodule

### tb/sv/ray_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster result checker
// Watches the command, result and register ports, keeps its own map and view
// registers, computes each cast's expected result and compares every field.
// ----------------------------------------------------------------------------
module ray_checker
   import rdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [POS_W-1:0]  csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [23:0]       req_tdata,
   input  logic              req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [55:0]       rsp_tdata,
   output int                fail_count,
   output int                pending_count
);

   logic [CELL_W-1:0] map_model [MAP_DEPTH];
   logic [POS_W-1:0]  pos_x, pos_y;
   logic [VEC_W-1:0]  dir_x, dir_y, plane_x, plane_y;
   result_type        hit_queue[$];

   assign pending_count = hit_queue.size();

   // Reciprocal of one ray component, saturated.
   function automatic longint unsigned step_len(longint r);
      longint unsigned a, q;
      if (r == 0) return DELTA_MAX;
      a = (r < 0) ? -r : r;
      q = (64'd1 << (2 * FRAC_BITS)) / a;
      return (q > DELTA_MAX) ? DELTA_MAX : q;
   endfunction

   // Distance from the player to the first boundary along one axis.
   function automatic longint unsigned first_edge(longint unsigned p, longint r,
                                                  longint unsigned d);
      longint unsigned f;
      f = p & (ONE_UNIT - 1);
      if (r >= 0) f = ONE_UNIT - f;
      return (f * d) >> FRAC_BITS;
   endfunction

   // Walks one ray through the map and builds the result.
   function automatic result_type cast_column(logic [COL_W-1:0] col);
      result_type res;
      longint cam, rx, ry, mx, my, sgx, sgy;
      longint unsigned dx, dy, sx, sy, wall_len, h, q, k, top, bot;
      int side, kind_hit;
      side = 0;
      kind_hit = 0;
      cam = longint'(((64'(col) * 2) << FRAC_BITS) / SCREEN_COLUMNS) - ONE_UNIT;
      rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> FRAC_BITS);
      ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> FRAC_BITS);
      dx = step_len(rx);
      dy = step_len(ry);
      sgx = (rx < 0) ? -1 : 1;
      sgy = (ry < 0) ? -1 : 1;
      mx = longint'(pos_x >> FRAC_BITS);
      my = longint'(pos_y >> FRAC_BITS);
      if (mx >= MAP_ROWS || my >= MAP_COLS) begin
         wall_len = 0;
      end else begin
         sx = first_edge(64'(pos_x), rx, dx);
         sy = first_edge(64'(pos_y), ry, dy);
         for (int n = 0; n < STEP_MAX; n++) begin
            if (sx < sy) begin
               sx += dx; mx += sgx; side = 0;
            end else begin
               sy += dy; my += sgy; side = 1;
            end
            if (mx < 0 || mx >= MAP_ROWS || my < 0 || my >= MAP_COLS) begin
               kind_hit = 0;
               break;
            end
            kind_hit = int'(map_model[MAP_AW'(mx * MAP_COLS + my)]);
            if (kind_hit != 0) break;
         end
         wall_len = side ? (sy - dy) : (sx - dx);
      end
      if (wall_len < ONE_UNIT) wall_len = ONE_UNIT;
      if (wall_len > DIST_MAX) wall_len = DIST_MAX;
      h = (64'(SCREEN_ROWS) << FRAC_BITS) / wall_len;
      q = h / 2;
      k = HALF_ROWS;
      top = (q > k) ? 0 : k - q;
      bot = k + q;
      if (bot > SCREEN_ROWS - 1) bot = SCREEN_ROWS - 1;
      res.column_out = col;
      res.draw_start = ROW_W'(top);
      res.draw_end = ROW_W'(bot);
      res.wall_side = side[0];
      res.wall_type = CELL_W'(kind_hit);
      res.wall_distance = DIST_W'(wall_len);
      return res;
   endfunction

   // Track register writes and accepted command beats.
   always @(posedge clock) begin
      if (reset) begin
         pos_x <= PLAYER_X_RST; pos_y <= PLAYER_Y_RST;
         dir_x <= DIR_X_RST; dir_y <= DIR_Y_RST;
         plane_x <= PLANE_X_RST; plane_y <= PLANE_Y_RST;
         for (int i = 0; i < MAP_DEPTH; i++) map_model[i] = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PLAYER_X: pos_x <= csr_wdata;
               CSR_PLAYER_Y: pos_y <= csr_wdata;
               CSR_DIR_X:    dir_x <= csr_wdata[VEC_W-1:0];
               CSR_DIR_Y:    dir_y <= csr_wdata[VEC_W-1:0];
               CSR_PLANE_X:  plane_x <= csr_wdata[VEC_W-1:0];
               CSR_PLANE_Y:  plane_y <= csr_wdata[VEC_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_MAP_WRITE)
               map_model[MAP_AW'(req_tdata[14:10] * MAP_COLS + req_tdata[19:15])] =
                  req_tdata[22:20];
            else if (req_tdata[9:0] < SCREEN_COLUMNS)
               hit_queue.push_back(cast_column(req_tdata[9:0]));
         end
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      result_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (hit_queue.size() == 0) begin
            $display("%t: unexpected result beat, actual %h", $realtime, got);
            fail_count <= fail_count + 1;
         end else begin
            want = hit_queue.pop_front();
            if (got !== want) begin
               $display("%t: column %0d expected %h actual %h", $realtime,
                        want.column_out, want, got);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray caster testbench
// Fills the map, casts directed and random columns under several view
// settings with random gaps on both streams; the checker judges the results.
// ----------------------------------------------------------------------------
module tb
   import rdc_pkg::*;
();

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [POS_W-1:0]  csr_wdata;
   logic              req_tvalid, req_tready, req_tuser;
   logic [23:0]       req_tdata;
   logic              rsp_tvalid, rsp_tready;
   logic [55:0]       rsp_tdata;
   int                fail_count, pending_count;

   grid_ray_caster_dda_core dut (.*);
   ray_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("Mismatches found");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 300);
   endfunction

   // Result side stalls.
   initial begin
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock iff rsp_tvalid);
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   task automatic send_beat(logic kind, logic [23:0] data);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock iff req_tready);
   endtask

   task automatic put_cell(int r, int c, int v);
      send_beat(KIND_MAP_WRITE, {1'b0, 3'(v), 5'(c), 5'(r), 10'd0});
   endtask

   task automatic cast(int col);
      send_beat(KIND_CAST, {14'd0, 10'(col)});
   endtask

   // One register write beat; the caller drops the write enable afterwards.
   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [POS_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Wait for every expected result, then let a final map write settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_view(int px, int py, int vx, int vy, int cx, int cy);
      write_reg(CSR_PLAYER_X, 21'(px));
      write_reg(CSR_PLAYER_Y, 21'(py));
      write_reg(CSR_DIR_X, 21'(vx));
      write_reg(CSR_DIR_Y, 21'(vy));
      write_reg(CSR_PLANE_X, 21'(cx));
      write_reg(CSR_PLANE_Y, 21'(cy));
      csr_we <= 1'b0;
   endtask

   int vec_lim [3] = '{131072, -131072, 0};

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset view, empty map: rays leave the grid; extreme columns.
      cast(0); cast(SCREEN_COLUMNS - 1); cast(320); cast(1023); cast(640);
      // Walls at every third cell of row 0 and in the start cell, extreme values.
      for (int i = 0; i < MAP_ROWS; i += 3) put_cell(0, i, 7);
      put_cell(22, 12, 5); put_cell(31, 31, 1); put_cell(5, 31, 2);
      put_cell(3, 0, 0);
      send_beat(KIND_MAP_WRITE, 24'hFFFFFF);
      cast(0); cast(319); cast(320); cast(639);
      drain();

      // Player at the far corner of the grid, then zero ray and tie cases.
      set_view(2097151, 2097151, 131072, -131072, -131072, 131072);
      cast(0); cast(639);
      drain();
      set_view(16 << 16, 16 << 16, 0, 0, 0, 0);
      cast(320); cast(100);
      drain();
      set_view(16 << 16 | 32768, 16 << 16 | 32768, 65536, 65536, 0, 0);
      cast(7);
      drain();

      // Random phases: walls, views and mostly casts.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph % 3 == 2)
            set_view($urandom_range(0, 2097151), $urandom_range(0, 2097151),
                     vec_lim[$urandom_range(0, 2)], vec_lim[$urandom_range(0, 2)],
                     vec_lim[$urandom_range(0, 2)], vec_lim[$urandom_range(0, 2)]);
         else
            set_view($urandom_range(0, (MAP_ROWS << 16) - 1),
                     $urandom_range(0, (MAP_COLS << 16) - 1),
                     $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072,
                     $urandom_range(0, 262143) - 131072, $urandom_range(0, 262143) - 131072);
         for (int n = 0; n < 36; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_beat(KIND_MAP_WRITE, 24'({1'b0, $urandom()} & 24'hFFFC00 |
                         24'($urandom_range(0, 1023))));
            else if ($urandom_range(0, 15) == 0)
               cast($urandom_range(0, 1023));
            else
               cast($urandom_range(0, SCREEN_COLUMNS - 1));
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
